// ===== sv/cpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcf_pkg - shared types and constants
// Slot count, index widths, entity layout and stream field widths for the
// circle pair collision finder.
// ----------------------------------------------------------------------------
package cpcf_pkg;

    localparam int MAX_ENTITIES = 32;
    localparam int IDX_W        = $clog2(MAX_ENTITIES);
    localparam int CNT_W        = $clog2(MAX_ENTITIES + 1);
    localparam int OUT_IDX_W    = 5;
    localparam int CFG_W        = 6;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // one slot of the entity store
    typedef struct packed {
        logic               hand;
        logic               coll;
        logic [13:0]        r;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } entity_t;

    localparam int ENT_W = $bits(entity_t);

    // pair test pipeline, last stage
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] j;
        entity_t          b;
        logic             touch;
    } pair_res_t;

endpackage

// ===== sv/circle_pair_collision_finder_core.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collision_finder_core - brute-force circle collision finder
// Loads entities into a slot RAM; a run request walks all ordered pairs and
// streams out colliding pairs, then a done item.
// ----------------------------------------------------------------------------
// Load request: written to the slot RAM in the cycle it is accepted.
// Run request: per outer slot, fetch it (ST_ALOAD, ST_ACAP), issue one inner
//   read per cycle unless a hit restarts the reads or waits on a full output,
//   then drain the pair test and write the outer slot back (ST_AWRITE).
// s_axis_tready is low for the whole pass. Reset clears the sequencer, the
//   output valid and active_count; the slot RAM holds garbage until loaded.
// ----------------------------------------------------------------------------
module circle_pair_collision_finder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: active_count
    input  logic                           cfg_we,
    input  logic [cpcf_pkg::CFG_W-1:0]     cfg_wdata,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [4:0] slot_index, [20:5] pos_x, [36:21] pos_y, [50:37] radius,
    // [51] collidable, [52] handled_in, [55:53] zero
    input  logic [cpcf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]                     s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [4:0] first_index, [9:5] second_index, [15:10] zero
    output logic [cpcf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] pair_found
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    import cpcf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALOAD,
        ST_ACAP,
        ST_ROW,
        ST_AWRITE,
        ST_DONE
    } state_t;

    // sequencer state
    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       active_reg, active_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       i_reg, i_next;       // outer slot
    logic [CNT_W-1:0]       j_reg, j_next;       // next inner slot to read
    entity_t                a_reg, a_next;       // outer entity, handled flag live
    logic                   rd_pending_reg, rd_pending_next;
    logic [IDX_W-1:0]       rd_j_reg, rd_j_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic                   out_last_reg, out_last_next;
    logic [OUT_IDX_W-1:0]   out_first_reg, out_first_next;
    logic [OUT_IDX_W-1:0]   out_second_reg, out_second_next;

    // request fields
    logic                   in_cmd;
    logic [4:0]             in_slot;
    entity_t                in_ent;
    logic                   in_take;
    logic [CNT_W-1:0]       cnt_run;

    // RAM port
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entity_t                ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    entity_t                ram_rdata;

    // pair test
    logic                   flush;
    logic                   pair_busy;
    pair_res_t              res;
    logic                   hit;
    logic                   out_free;
    logic                   out_load;

    assign in_cmd      = s_axis_tuser[0];
    assign in_slot     = s_axis_tdata[4:0];
    assign in_ent.x    = s_axis_tdata[20:5];
    assign in_ent.y    = s_axis_tdata[36:21];
    assign in_ent.r    = s_axis_tdata[50:37];
    assign in_ent.coll = s_axis_tdata[51];
    assign in_ent.hand = s_axis_tdata[52];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // count above the slot count saturates
    assign cnt_run = (32'(active_reg) > MAX_ENTITIES) ? CNT_W'(MAX_ENTITIES)
                                                      : CNT_W'(active_reg);

    assign out_free = !out_valid_reg || m_axis_tready;

    // a pair is reported unless self, not collidable, apart, or both handled
    assign hit = res.valid && (state_reg == ST_ROW) && (res.j != i_reg) &&
                 a_reg.coll && res.b.coll && res.touch &&
                 !(a_reg.hand && res.b.hand);

    // any hit restarts the read stream after it: in-flight reads may be stale
    assign flush = hit;

    cpcf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTITIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpcf_pair_test u_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (flush),
        .in_valid (rd_pending_reg),
        .in_j     (rd_j_reg),
        .in_b     (ram_rdata),
        .a        (a_reg),
        .busy     (pair_busy),
        .res      (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        active_next     = cfg_we ? cfg_wdata : active_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        rd_pending_next = 1'b0;
        rd_j_next       = rd_j_reg;
        out_load        = 1'b0;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        ram_we          = 1'b0;
        ram_waddr       = i_reg;
        ram_wdata       = a_reg;
        ram_raddr       = j_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        // loads beyond the slot count are dropped
                        ram_we    = (32'(in_slot) < MAX_ENTITIES);
                        ram_waddr = IDX_W'(in_slot);
                        ram_wdata = in_ent;
                    end
                    else
                    begin
                        cnt_next = cnt_run;
                        i_next   = '0;
                        if (cnt_run < CNT_W'(2))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_ALOAD;
                        end
                    end
                end
            end

            ST_ALOAD:
            begin
                ram_raddr  = i_reg;
                state_next = ST_ACAP;
            end

            ST_ACAP:
            begin
                a_next     = ram_rdata;
                j_next     = '0;
                state_next = ST_ROW;
            end

            ST_ROW:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        // report, mark both handled
                        out_load        = 1'b1;
                        out_found_next  = 1'b1;
                        out_last_next   = 1'b0;
                        out_first_next  = OUT_IDX_W'(i_reg);
                        out_second_next = OUT_IDX_W'(res.j);
                        a_next.hand     = 1'b1;
                        ram_we          = 1'b1;
                        ram_waddr       = res.j;
                        ram_wdata       = res.b;
                        ram_wdata.hand  = 1'b1;
                        j_next          = CNT_W'(res.j) + CNT_W'(1);
                    end
                    else
                    begin
                        // output full: replay this inner slot
                        j_next = CNT_W'(res.j);
                    end
                end
                else if (j_reg != cnt_reg)
                begin
                    rd_pending_next = 1'b1;
                    rd_j_next       = j_reg[IDX_W-1:0];
                    j_next          = j_reg + CNT_W'(1);
                end
                else if (!rd_pending_reg && !pair_busy && !res.valid)
                begin
                    state_next = ST_AWRITE;
                end
            end

            ST_AWRITE:
            begin
                // outer entity back with its handled flag
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = a_reg;
                if (CNT_W'(i_reg) + CNT_W'(1) == cnt_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_ALOAD;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_found_next  = 1'b0;
                    out_last_next   = 1'b1;
                    out_first_next  = '0;
                    out_second_next = '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            cnt_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        rd_j_reg       <= rd_j_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - 2 * OUT_IDX_W)'(0), out_second_reg, out_first_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

    // pipeline is empty whenever new requests are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(rd_pending_reg || pair_busy))
        else $error("pair pipeline busy while idle");

    // an item is never loaded over an untaken one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten");

    // writes during a row are reports and always set the handled flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_ROW)) |-> (ram_wdata.hand && out_load))
        else $error("row write without report");

endmodule

// ===== sv/cpcf_ram.sv =====
// ----------------------------------------------------------------------------
// cpcf_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module cpcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/cpcf_pair_test.sv =====
// ----------------------------------------------------------------------------
// cpcf_pair_test - two-stage circle overlap test
// Stage 1: absolute deltas and radius sum. Stage 2: squares.
// Output: (ra + rb)^2 > dx^2 + dy^2.
// ----------------------------------------------------------------------------
module cpcf_pair_test (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   flush,
    input  logic                   in_valid,
    input  logic [cpcf_pkg::IDX_W-1:0] in_j,
    input  cpcf_pkg::entity_t      in_b,
    input  cpcf_pkg::entity_t      a,
    output logic                   busy,
    output cpcf_pkg::pair_res_t    res
);

    import cpcf_pkg::*;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] ndx;
    logic signed [16:0] ndy;

    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_j_reg;
    entity_t            s1_b_reg;
    logic [15:0]        s1_adx_reg;
    logic [15:0]        s1_ady_reg;
    logic [14:0]        s1_rs_reg;

    logic               s2_valid_reg;
    logic [IDX_W-1:0]   s2_j_reg;
    entity_t            s2_b_reg;
    logic [31:0]        s2_dx2_reg;
    logic [31:0]        s2_dy2_reg;
    logic [29:0]        s2_rs2_reg;

    logic [31:0]        sq_x;
    logic [31:0]        sq_y;
    logic [29:0]        sq_r;
    logic [32:0]        d2;

    assign dx  = {a.x[15], a.x} - {in_b.x[15], in_b.x};
    assign dy  = {a.y[15], a.y} - {in_b.y[15], in_b.y};
    assign ndx = -dx;
    assign ndy = -dy;

    assign sq_x = 32'(s1_adx_reg) * 32'(s1_adx_reg);
    assign sq_y = 32'(s1_ady_reg) * 32'(s1_ady_reg);
    assign sq_r = 30'(s1_rs_reg) * 30'(s1_rs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid && !flush;
            s2_valid_reg <= s1_valid_reg && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_j_reg   <= in_j;
        s1_b_reg   <= in_b;
        s1_adx_reg <= dx[16] ? ndx[15:0] : dx[15:0];
        s1_ady_reg <= dy[16] ? ndy[15:0] : dy[15:0];
        s1_rs_reg  <= {1'b0, a.r} + {1'b0, in_b.r};
        s2_j_reg   <= s1_j_reg;
        s2_b_reg   <= s1_b_reg;
        s2_dx2_reg <= sq_x;
        s2_dy2_reg <= sq_y;
        s2_rs2_reg <= sq_r;
    end

    assign d2 = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};

    assign busy      = s1_valid_reg || s2_valid_reg;
    assign res.valid = s2_valid_reg;
    assign res.j     = s2_j_reg;
    assign res.b     = s2_b_reg;
    assign res.touch = {3'b000, s2_rs2_reg} > d2;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - circle pair collision finder core
// Loads entities over the request stream and runs collision passes at several
// settings of active_count. Every request is mirrored into a local model of
// the slot store; each pass is swept there and the reported pairs and the done
// item are checked in order against the result stream.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cpcf_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;      // load is written in its accept cycle
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 600;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 31;
    localparam int RANDOM_COUNT   = -1;     // pick active_count at run time
    localparam int NUM_DIRECTED   = 26;

    // active_count per random phase; four phases per idling mode
    localparam int PHASE_CFG [NUM_PHASES] = '{
        3, 8, 0, 33,
        5, 63, 1, RANDOM_COUNT,
        32, 6, RANDOM_COUNT, 4
    };

    localparam logic [15:0] CORNER_VALS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_RUN,
        ROW_CFG
    } row_kind_e;

    // one stimulus step: a request, or a write of active_count
    typedef struct packed {
        row_kind_e   kind;
        logic [4:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [13:0] r;
        logic        coll;
        logic        hand;
        logic [5:0]  cfg;
        logic        fixed;         // expected result typed in below
        logic        fixed_pair;    // fixed run reports one pair before done
        logic [4:0]  fixed_first;
        logic [4:0]  fixed_second;
    } stim_row_t;

    typedef struct packed {
        logic       pair_found;
        logic [4:0] first_idx;
        logic [4:0] second_idx;
        logic       last;
    } report_t;

    // Directed table. Rows with fixed set carry the obvious answer; the rest
    // are left to the pass model.
    stim_row_t dir_tab [NUM_DIRECTED] = '{
        // empty pass straight after reset
        '{ROW_CFG,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b1, 1'b0, 5'd0, 5'd0},
        // two overlapping 1 px circles
        '{ROW_LOAD, 5'd0, 16'h0000, 16'h0000, 14'd16,    1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_LOAD, 5'd1, 16'h0010, 16'h0000, 14'd16,    1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        // single slot: nothing to pair with
        '{ROW_CFG,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd1, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b1, 1'b0, 5'd0, 5'd0},
        '{ROW_CFG,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd2, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b1, 1'b1, 5'd0, 5'd1},
        // both now handled
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b1, 1'b0, 5'd0, 5'd0},
        // opposite corners, largest radii
        '{ROW_LOAD, 5'd0, 16'h8000, 16'h8000, 14'h3FFF,  1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_LOAD, 5'd1, 16'h7FFF, 16'h7FFF, 14'h3FFF,  1'b1, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        // coincident, one handled: still reported
        '{ROW_LOAD, 5'd1, 16'h8000, 16'h8000, 14'd0,     1'b1, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b1, 1'b1, 5'd0, 5'd1},
        // exact tangency is not a hit
        '{ROW_LOAD, 5'd0, 16'h0000, 16'h0000, 14'd24,    1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_LOAD, 5'd1, 16'h0030, 16'h0000, 14'd24,    1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        // zero radii at the same point
        '{ROW_LOAD, 5'd0, 16'h0000, 16'h0000, 14'd0,     1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_LOAD, 5'd1, 16'h0000, 16'h0000, 14'd0,     1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        // overlap, but one side not collidable
        '{ROW_LOAD, 5'd0, 16'h0000, 16'h0000, 14'd100,   1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_LOAD, 5'd1, 16'h0000, 16'h0000, 14'd100,   1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b1, 1'b0, 5'd0, 5'd0},
        // first handled, second not, then both handled
        '{ROW_LOAD, 5'd0, 16'h0000, 16'h0000, 14'd100,   1'b1, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0},
        '{ROW_RUN,  5'd0, 16'h0000, 16'h0000, 14'd0,     1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0, 5'd0}
    };

    // ------------------------------------------------------------------------
    // DUT signals; all inputs start at a known value
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = CMD_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    // ------------------------------------------------------------------------
    // Pass model state and scoreboard
    // ------------------------------------------------------------------------
    entity_t    slot_mirror [MAX_ENTITIES];
    logic [5:0] count_mirror = '0;
    report_t    sweep_q [$];        // results of the latest modelled pass
    report_t    pending [$];        // results still owed by the DUT

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    int err_count  = 0;
    int n_loads    = 0;
    int n_passes   = 0;
    int n_settings = 0;
    int n_pairs    = 0;
    int n_done     = 0;

    circle_pair_collision_finder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Pass model
    // ------------------------------------------------------------------------

    // exact squared test on Q12.4 values; strict, so tangency misses
    function automatic logic circles_overlap(entity_t a, entity_t b);
        longint dx;
        longint dy;
        longint rs;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        rs = longint'(a.r) + longint'(b.r);
        return (rs * rs) > (dx * dx + dy * dy);
    endfunction

    // Walk all ordered pairs below the effective count, reporting and marking
    // handled as the hardware does; finishes with the done item.
    function automatic void sweep_pairs();
        int      n;
        report_t rep;
        sweep_q.delete();
        n = (int'(count_mirror) > MAX_ENTITIES) ? MAX_ENTITIES : int'(count_mirror);
        for (int a = 0; a < n; a++) begin
            for (int b = 0; b < n; b++) begin
                if (a != b && slot_mirror[a].coll && slot_mirror[b].coll &&
                    circles_overlap(slot_mirror[a], slot_mirror[b]) &&
                    !(slot_mirror[a].hand && slot_mirror[b].hand)) begin
                    rep = '{1'b1, 5'(a), 5'(b), 1'b0};
                    sweep_q.insert(sweep_q.size(), rep);
                    slot_mirror[a].hand = 1'b1;
                    slot_mirror[b].hand = 1'b1;
                end
            end
        end
        rep = '{1'b0, 5'd0, 5'd0, 1'b1};
        sweep_q.insert(sweep_q.size(), rep);
    endfunction

    // an accepted request: update the mirror and queue what it owes
    function automatic void absorb_request(stim_row_t row);
        report_t rep;
        if (row.kind == ROW_LOAD) begin
            slot_mirror[row.slot] = '{row.hand, row.coll, row.r, row.y, row.x};
            n_loads++;
        end else begin
            sweep_pairs();
            n_passes++;
            if (row.fixed) begin
                if (row.fixed_pair) begin
                    rep = '{1'b1, row.fixed_first, row.fixed_second, 1'b0};
                    pending.insert(pending.size(), rep);
                end
                rep = '{1'b0, 5'd0, 5'd0, 1'b1};
                pending.insert(pending.size(), rep);
            end else begin
                foreach (sweep_q[k])
                    pending.insert(pending.size(), sweep_q[k]);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one request with optional leading gaps and hold it until taken.
    // tvalid stays high across back-to-back requests.
    task automatic send_request(input stim_row_t row);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= (row.kind == ROW_RUN) ? CMD_RUN : CMD_LOAD;
        s_axis_tdata  <= {3'b000, row.hand, row.coll, row.r, row.y, row.x, row.slot};
        do @(posedge clk); while (!s_axis_tready);
        absorb_request(row);
    endtask

    // active_count only changes with the block idle and every result in
    task automatic write_count(input logic [5:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        count_mirror = value;
        n_settings++;
    endtask

    // Mostly clustered circles so passes find real collisions; some full
    // range and corner values. Loads favour slots inside the active window.
    function automatic stim_row_t random_request(bit force_run);
        stim_row_t row;
        int        eff;
        int        mode;
        row = '0;
        eff = (int'(count_mirror) > MAX_ENTITIES) ? MAX_ENTITIES : int'(count_mirror);
        if (force_run || $urandom_range(0, 4) == 0) begin
            row.kind = ROW_RUN;
            return row;
        end
        row.kind = ROW_LOAD;
        if (eff > 0 && $urandom_range(0, 99) < 80)
            row.slot = 5'($urandom_range(0, eff - 1));
        else
            row.slot = 5'($urandom_range(0, MAX_ENTITIES - 1));
        mode = $urandom_range(0, 99);
        if (mode < 80) begin
            row.x = 16'($urandom_range(0, 2047)) - 16'd1024;
            row.y = 16'($urandom_range(0, 2047)) - 16'd1024;
            row.r = 14'($urandom_range(0, 700));
        end else if (mode < 95) begin
            row.x = 16'($urandom);
            row.y = 16'($urandom);
            row.r = 14'($urandom);
        end else begin
            row.x = CORNER_VALS[$urandom_range(0, 3)];
            row.y = CORNER_VALS[$urandom_range(0, 3)];
            row.r = ($urandom_range(0, 1) == 1) ? 14'h3FFF : 14'd0;
        end
        row.coll = ($urandom_range(0, 99) < 85);
        row.hand = ($urandom_range(0, 99) < 20);
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random tready, or a counted hold-off when asked for
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req) begin
            hold_req      = 1'b0;
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest one owed
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge clk) begin : result_check
        report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, pair_found", m_axis_tuser[0], 0);
            end else begin
                want = pending.pop_front();
                if (m_axis_tuser[0] !== want.pair_found)
                    report_mismatch("pair_found", m_axis_tuser[0], want.pair_found);
                if (m_axis_tdata[4:0] !== want.first_idx)
                    report_mismatch("first_index", m_axis_tdata[4:0], want.first_idx);
                if (m_axis_tdata[9:5] !== want.second_idx)
                    report_mismatch("second_index", m_axis_tdata[9:5], want.second_idx);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
                if (want.pair_found)
                    n_pairs++;
                else
                    n_done++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no request and no result accepted
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without progress, %0d results owed",
                         quiet_cycles, pending.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        stim_row_t row;
        int        cnt;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender and receiver both idling
        tx_idle_pct = 24;
        rx_idle_pct = 67;
        foreach (dir_tab[d]) begin
            if (dir_tab[d].kind == ROW_CFG)
                write_count(dir_tab[d].cfg);
            else
                send_request(dir_tab[d]);
        end

        // fill every slot so no pass can touch an unloaded entry
        for (int s = 0; s < MAX_ENTITIES; s++) begin
            row      = random_request(1'b0);
            row.kind = ROW_LOAD;
            row.slot = 5'(s);
            send_request(row);
        end

        // random phases; each opens with a pass
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 4)
                0: begin tx_idle_pct = 24; rx_idle_pct = 67; end
                1: begin tx_idle_pct = 67; rx_idle_pct = 24; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            cnt = (PHASE_CFG[p] == RANDOM_COUNT) ? $urandom_range(2, 16) : PHASE_CFG[p];
            write_count(6'(cnt));
            // first phase without idling: hold the result side off while the
            // sender keeps offering, so the input side backs up
            if (p == 8)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                row = random_request(i == 0);
                send_request(row);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d entity loads and %0d collision passes over %0d active_count values",
                 n_loads, n_passes, n_settings);
        $display("Checked %0d colliding pairs and %0d done items, %0d mismatches",
                 n_pairs, n_done, err_count);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
